// ===== hw/rtl/sqsd_pkg.sv =====
`timescale 1ns / 1ps

package sqsd_pkg;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [2:0] STAT_ENQ    = 3'd0;
  localparam logic [2:0] STAT_DEQ    = 3'd1;
  localparam logic [2:0] STAT_EMPTY  = 3'd2;
  localparam logic [2:0] STAT_FULL   = 3'd3;
  localparam logic [2:0] STAT_BADIDX = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DLEN,
    S_DTOP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic dlen;
    logic dtop;
    logic done;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic scan_pend;
  } dp_stat_t;

endpackage

// ===== hw/rtl/sqsd_ctrl.sv =====
`timescale 1ns / 1ps

module sqsd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  output logic             out_valid,
  input  logic             out_ready,
  output sqsd_pkg::dp_cmd_t cmd,
  input  sqsd_pkg::dp_stat_t stat
);
  import sqsd_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (func == FUNC_ENQ) ? S_SCAN : S_DLEN;
        end
      end
      S_SCAN: begin
        // last compare happens in the cycle where no further read is issued
        if (!stat.scan_more && stat.scan_pend) begin
          state_next = S_DONE;
        end
      end
      S_DLEN: state_next = S_DTOP;
      S_DTOP: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: cmd.scan = 1'b1;
      S_DLEN: cmd.dlen = 1'b1;
      S_DTOP: cmd.dtop = 1'b1;
      S_DONE: cmd.done = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_done_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> out_valid)
    else $error("result register not loaded");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> state == S_DONE)
    else $error("result overwritten while receiver stalled");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE)
    else $error("accepted transaction not processed");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.dlen, cmd.dtop, cmd.done}))
    else $error("conflicting datapath commands");

endmodule

// ===== hw/rtl/sqsd_datapath.sv =====
`timescale 1ns / 1ps

module sqsd_datapath #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16,
  parameter int SOURCE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [3:0]         cfg_data,
  input  logic               func,
  input  logic [7:0]         source_id,
  input  logic [31:0]        message_number,
  input  logic [2:0]         queue_index,
  input  sqsd_pkg::dp_cmd_t  cmd,
  output sqsd_pkg::dp_stat_t stat,
  output logic [2:0]         status,
  output logic [2:0]         chosen_queue,
  output logic [7:0]         out_source_id,
  output logic [31:0]        out_message_number,
  output logic [4:0]         length_after
);
  import sqsd_pkg::*;

  localparam int QW          = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CW          = $clog2(NUM_STACKS + 1);
  localparam int LW          = $clog2(STACK_DEPTH + 1);
  localparam int SW          = (SOURCE_BITS < 8) ? SOURCE_BITS : 8;
  localparam int ENTRIES     = NUM_STACKS * STACK_DEPTH;
  localparam int AW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RESET_COUNT = (NUM_STACKS < 8) ? NUM_STACKS : 8;
  localparam logic [AW-1:0] DEPTH_A = AW'(STACK_DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);

  logic [CW-1:0]    act_count;
  logic             func_r;
  logic [SW-1:0]    src_r;
  logic [31:0]      msg_r;
  logic [2:0]       qi_r;
  logic [31:0]      qi_ext;
  logic [QW-1:0]    qsel;
  logic             bad;

  logic [CW-1:0]    ridx;
  logic [QW-1:0]    cidx;
  logic             pend;
  logic             scan_more;
  logic [QW-1:0]    best;
  logic [LW-1:0]    best_len;

  logic [LW-1:0]    len_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] len_vld;
  logic [LW-1:0]    len_q;
  logic             vld_q;
  logic [LW-1:0]    len_eff;
  logic             len_rd;
  logic [QW-1:0]    len_raddr;
  logic             len_we;
  logic [QW-1:0]    len_waddr;
  logic [LW-1:0]    len_wdata;

  logic [SW+31:0]   stk_mem [ENTRIES];
  logic [SW+31:0]   stk_q;
  logic [AW-1:0]    stk_addr;
  logic             stk_we;
  logic             is_enq;
  logic             full;

  // register is clamped on write, so downstream logic only sees 1..NUM_STACKS
  always_ff @(posedge clk) begin
    if (rst) begin
      act_count <= CW'(RESET_COUNT);
    end else if (cfg_valid) begin
      if (cfg_data == 4'd0) begin
        act_count <= CW'(1);
      end else if (32'(cfg_data) > NUM_STACKS) begin
        act_count <= CW'(NUM_STACKS);
      end else begin
        act_count <= CW'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      src_r  <= source_id[SW-1:0];
      msg_r  <= message_number;
      qi_r   <= queue_index;
    end
  end

  assign qi_ext    = 32'(qi_r);
  assign qsel      = qi_ext[QW-1:0];
  assign bad       = qi_ext >= 32'(act_count);
  assign is_enq    = (func_r == FUNC_ENQ);
  assign scan_more = ridx < act_count;
  assign len_eff   = vld_q ? len_q : '0;
  assign full      = best_len >= DEPTH_L;

  assign stat.scan_more = scan_more;
  assign stat.scan_pend = pend;

  // scan: one length read issued per cycle, compared in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      ridx <= '0;
      pend <= 1'b0;
    end else if (cmd.load) begin
      ridx <= '0;
      pend <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_more) begin
        ridx <= ridx + CW'(1);
      end
      pend <= scan_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best     <= '0;
      best_len <= '1;
    end else if (cmd.scan && pend && (len_eff < best_len)) begin
      best     <= cidx;
      best_len <= len_eff;
    end
    if (cmd.scan && scan_more) begin
      cidx <= ridx[QW-1:0];
    end
  end

  assign len_rd    = (cmd.scan && scan_more) || cmd.dlen;
  assign len_raddr = cmd.dlen ? qsel : ridx[QW-1:0];

  always_comb begin
    len_we    = 1'b0;
    len_waddr = qsel;
    len_wdata = len_eff - LW'(1);
    if (cmd.done) begin
      if (is_enq) begin
        len_we    = !full;
        len_waddr = best;
        len_wdata = best_len + LW'(1);
      end else begin
        len_we    = !bad && (len_eff != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (len_rd) begin
      len_q <= len_mem[len_raddr];
      vld_q <= len_vld[len_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
    end else if (len_we) begin
      len_vld[len_waddr] <= 1'b1;
    end
  end

  // push writes slot best_len of the chosen stack, pop reads slot len-1
  assign stk_addr = is_enq ? (AW'(best) * DEPTH_A + AW'(best_len))
                           : (AW'(qsel) * DEPTH_A + AW'(len_eff - LW'(1)));
  assign stk_we   = cmd.done && is_enq && !full;

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= {src_r, msg_r};
    end
    if (cmd.dtop) begin
      stk_q <= stk_mem[stk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_source_id      <= '0;
      out_message_number <= '0;
      if (is_enq) begin
        chosen_queue <= 3'(best);
        if (full) begin
          status       <= STAT_FULL;
          length_after <= 5'(best_len);
        end else begin
          status       <= STAT_ENQ;
          length_after <= 5'(best_len + LW'(1));
        end
      end else begin
        chosen_queue <= qi_r;
        length_after <= '0;
        if (bad) begin
          status <= STAT_BADIDX;
        end else if (len_eff == '0) begin
          status <= STAT_EMPTY;
        end else begin
          status             <= STAT_DEQ;
          out_source_id      <= 8'(stk_q[SW+31:32]);
          out_message_number <= stk_q[31:0];
          length_after       <= 5'(len_eff - LW'(1));
        end
      end
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> ridx <= act_count)
    else $error("scan index beyond active queues");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    stk_we |-> best_len < DEPTH_L)
    else $error("push beyond stack depth");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (act_count != '0) && (32'(act_count) <= NUM_STACKS))
    else $error("active count out of range");

endmodule

// ===== hw/rtl/shortest_queue_stack_dispatcher_unit.sv =====
`timescale 1ns / 1ps

// Join-shortest-queue dispatcher with one LIFO stack per consumer.
// Input channel (in_valid/in_ready): func 0 pushes {source_id, message_number}
// onto the active stack with the fewest entries (lowest index on a tie);
// func 1 pops the top of stack queue_index. Each transaction gives exactly
// one result on the output channel (out_valid/out_ready) with a status code.
// Config channel (cfg_valid/cfg_ready, cfg_data): number of active stacks,
// clamped to 1..NUM_STACKS; write it only while the block is idle.
// Timing: one transaction at a time. With n the clamped active count, an
// enqueue has its result register loaded after the length scan over the n
// stacks, which reads one length per cycle and compares each in the next cycle.
// A dequeue steps through length read, stack read and result load. in_ready
// rises again the cycle after the result is loaded, so the next transaction
// overlaps a waiting result. Receiver stall: a new result is held back until
// the previous one is taken, and in_ready stays low meanwhile.
// Reset: all stacks empty, active count = min(NUM_STACKS, 8); stack contents are not cleared.
module shortest_queue_stack_dispatcher_unit #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16,
  parameter int SOURCE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  source_id,
  input  logic [31:0] message_number,
  input  logic [2:0]  queue_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [2:0]  chosen_queue,
  output logic [7:0]  out_source_id,
  output logic [31:0] out_message_number,
  output logic [4:0]  length_after
);
  import sqsd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sqsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sqsd_datapath #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH),
    .SOURCE_BITS (SOURCE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .func               (func),
    .source_id          (source_id),
    .message_number     (message_number),
    .queue_index        (queue_index),
    .cmd                (cmd),
    .stat               (stat),
    .status             (status),
    .chosen_queue       (chosen_queue),
    .out_source_id      (out_source_id),
    .out_message_number (out_message_number),
    .length_after       (length_after)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sqsd_pkg::*;

  localparam int NQ           = 8;
  localparam int DEPTH        = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_PHASES   = 13;
  localparam int PHASE_ITEMS  = 150;

  typedef struct packed {
    logic        func;
    logic [7:0]  src;
    logic [31:0] msg;
    logic [2:0]  qi;
  } job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  queue;
    logic [7:0]  src;
    logic [31:0] msg;
    logic [4:0]  len;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_ENQ;
  logic [7:0]  source_id = 8'd0;
  logic [31:0] message_number = 32'd0;
  logic [2:0]  queue_index = 3'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [2:0]  chosen_queue;
  logic [7:0]  out_source_id;
  logic [31:0] out_message_number;
  logic [4:0]  length_after;

  shortest_queue_stack_dispatcher_unit dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .func               (func),
    .source_id          (source_id),
    .message_number     (message_number),
    .queue_index        (queue_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .chosen_queue       (chosen_queue),
    .out_source_id      (out_source_id),
    .out_message_number (out_message_number),
    .length_after       (length_after)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  job_t     job_backlog[$];
  outcome_t predicted_outcomes[$];
  int       queued_count = 0;
  int       accepted_count = 0;
  int       errors = 0;
  int       cycle_count = 0;
  logic     quiet = 1'b0;
  int       hold_len = 0;

  logic [3:0] phase_cfg [NUM_PHASES] = '{4'd15, 4'd8, 4'd1, 4'd3, 4'd2, 4'd5, 4'd8,
                                         4'd4, 4'd1, 4'd7, 4'd6, 4'd0, 4'd9};

  // shadow of the block's state
  logic [3:0]  active_setting;
  logic [4:0]  depth_of [NQ];
  logic [39:0] stack_mem [NQ*DEPTH];

  function automatic int live_queues(logic [3:0] a);
    if (a == 4'd0) return 1;
    if (a > NQ) return NQ;
    return int'(a);
  endfunction

  function automatic outcome_t dispatch(job_t j);
    int n;
    int best;
    int slot;
    outcome_t r;
    n = live_queues(active_setting);
    r = '0;
    if (j.func == FUNC_ENQ) begin
      best = 0;
      for (int i = 1; i < n; i++)
        if (depth_of[i] < depth_of[best]) best = i;
      r.queue = best[2:0];
      if (depth_of[best] >= DEPTH) begin
        r.status = STAT_FULL;
        r.len = 5'(DEPTH);
      end else begin
        slot = best * DEPTH + int'(depth_of[best]);
        stack_mem[slot] = {j.src, j.msg};
        depth_of[best] = depth_of[best] + 5'd1;
        r.status = STAT_ENQ;
        r.len = depth_of[best];
      end
    end else begin
      r.queue = j.qi;
      if (int'(j.qi) >= n) begin
        r.status = STAT_BADIDX;
      end else if (depth_of[j.qi] == 5'd0) begin
        r.status = STAT_EMPTY;
      end else begin
        depth_of[j.qi] = depth_of[j.qi] - 5'd1;
        slot = int'(j.qi) * DEPTH + int'(depth_of[j.qi]);
        {r.src, r.msg} = stack_mem[slot];
        r.status = STAT_DEQ;
        r.len = depth_of[j.qi];
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // sender
  int   send_gap = 0;
  job_t cur_job;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (job_backlog.size() != 0) begin
        cur_job = job_backlog.pop_front();
        in_valid <= 1'b1;
        func <= cur_job.func;
        source_id <= cur_job.src;
        message_number <= cur_job.msg;
        queue_index <= cur_job.qi;
        send_gap = quiet ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver; the long hold-off is counted here
  int   rx_gap = 0;
  int   hold_cnt = 0;
  logic hold_started = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_gap = quiet ? 0 : $urandom_range(0, 7);
      if (hold_len != 0 && !hold_started) begin
        hold_cnt = hold_len;
        hold_started = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // predict on every accepted transaction, track register writes
  always @(posedge clk) begin
    job_t j;
    if (rst) begin
      active_setting = 4'd8;
      for (int i = 0; i < NQ; i++) depth_of[i] = 5'd0;
    end else begin
      if (cfg_valid && cfg_ready) active_setting = cfg_data;
      if (in_valid && in_ready) begin
        j = '{func, source_id, message_number, queue_index};
        predicted_outcomes.push_back(dispatch(j));
        accepted_count++;
      end
    end
  end

  // compare results
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d queue %0d",
                 $time, status, chosen_queue);
        errors++;
      end else begin
        want = predicted_outcomes.pop_front();
        check_field("status", want.status, status);
        check_field("chosen_queue", want.queue, chosen_queue);
        check_field("out_source_id", want.src, out_source_id);
        check_field("out_message_number", want.msg, out_message_number);
        check_field("length_after", want.len, length_after);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** shortest_queue_stack_dispatcher_unit: FAILED **");
      $finish;
    end
  end

  task automatic add_job(logic f, logic [7:0] s, logic [31:0] m, logic [2:0] q);
    job_t j;
    j = '{f, s, m, q};
    job_backlog.push_back(j);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || predicted_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(logic [3:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    int enq_pct;
    logic f;
    logic [2:0] q;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset setting: all eight stacks live
    add_job(FUNC_ENQ, 8'hFF, 32'hFFFF_FFFF, 3'd7);
    add_job(FUNC_ENQ, 8'h00, 32'h0000_0000, 3'd0);
    add_job(FUNC_ENQ, 8'hA5, 32'h5A5A_5A5A, 3'd3);
    add_job(FUNC_DEQ, 8'h00, 32'h0, 3'd0);
    add_job(FUNC_DEQ, 8'h00, 32'h0, 3'd0);
    add_job(FUNC_DEQ, 8'h00, 32'h0, 3'd7);
    add_job(FUNC_DEQ, 8'h00, 32'h0, 3'd1);
    wait_drained();

    // zero acts as one stack; stack 2 keeps its entry out of reach
    write_active(4'd0);
    add_job(FUNC_DEQ, 8'h00, 32'h0, 3'd7);
    add_job(FUNC_DEQ, 8'h00, 32'h0, 3'd1);
    for (int i = 0; i < DEPTH + 1; i++)
      add_job(FUNC_ENQ, 8'(i * 17), 32'h1000_0000 + i, 3'(i));
    add_job(FUNC_DEQ, 8'h00, 32'h0, 3'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_active(phase_cfg[p]);
      n = live_queues(phase_cfg[p]);
      quiet <= (p % 4 == 1);
      if (p == 2) hold_len <= 400;
      enq_pct = (p % 3 == 0) ? 75 : (p % 3 == 1) ? 30 : 55;
      repeat (PHASE_ITEMS) begin
        f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        // mostly live stacks, now and then any index
        q = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(0, n - 1));
        add_job(f, 8'($urandom_range(0, 255)), $urandom, q);
      end
    end

    wait_drained();
    if (errors == 0)
      $display("** shortest_queue_stack_dispatcher_unit: PASSED **");
    else
      $display("** shortest_queue_stack_dispatcher_unit: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sqsd_pkg.sv
hw/rtl/sqsd_ctrl.sv
hw/rtl/sqsd_datapath.sv
hw/rtl/shortest_queue_stack_dispatcher_unit.sv
dv/tb.sv
